### hdl/pec15rfc_pkg.sv
// Shared types, constants and CRC-15 functions for the PEC-15 read frame checker.
// No dependencies; imported by every module of the block.
package pec15rfc_pkg;

  // CRC-15 polynomial and seed used by the monitor chips
  localparam logic [15:0] PEC_POLY = 16'h4599;
  localparam logic [15:0] PEC_SEED = 16'd16;

  // Chain size limits; the chip counter is 4 bits wide
  localparam int MAX_ICS = 16;
  localparam int CHIP_W = 4;
  localparam int NUM_ICS_W = 5;
  localparam logic [NUM_ICS_W-1:0] CHIP_LIMIT =
    NUM_ICS_W'((MAX_ICS < (1 << CHIP_W)) ? MAX_ICS : (1 << CHIP_W));
  localparam logic [NUM_ICS_W-1:0] NUM_ICS_RESET = 5'd1;

  // Byte positions inside an 8-byte frame
  localparam logic [2:0] POS_CHECK_LO = 3'd6;
  localparam logic [2:0] POS_CHECK_HI = 3'd7;

  // Result kinds
  localparam logic KIND_CELL   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Control from the frame sequencer to the CRC unit
  typedef struct packed {
    logic accept;     // input transaction this cycle
    logic restart;    // first byte of a read: reseed before the byte
    logic frame_end;  // last check byte: reseed after the byte
  } crc_ctl_t;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [3:0]  ic_index;
    logic [3:0]  cell_number;
    logic [15:0] cell_code;
    logic        frame_pec_bad;
    logic        read_pec_bad;
    logic        last_frame;
  } result_t;

  // Byte-wide CRC-15 table entry, eight bit steps
  function automatic logic [15:0] pec_entry(input logic [7:0] idx);
    logic [15:0] r;
    r = {1'b0, idx, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ PEC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Fold one received byte into the remainder
  function automatic logic [15:0] pec_update(input logic [15:0] crc, input logic [7:0] rx);
    logic [7:0] addr;
    addr = crc[14:7] ^ rx;
    return {crc[7:0], 8'h00} ^ pec_entry(addr);
  endfunction

endpackage

### hdl/pec15rfc_crc.sv
// Running CRC-15 remainder over the bytes of one frame.
// Depends on pec15rfc_pkg.
module pec15rfc_crc import pec15rfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  crc_ctl_t   ctl,
  input  logic [7:0] rx_byte,
  output logic       pec_bad
);

  logic [15:0] crc;
  logic [15:0] crc_seeded;
  logic [15:0] crc_next;

  // Reseed on a new read, then fold in the byte
  always_comb begin
    crc_seeded = ctl.restart ? PEC_SEED : crc;
    crc_next   = pec_update(crc_seeded, rx_byte);
  end

  // Shifted remainder nonzero means a bad check (only used on the last byte)
  assign pec_bad = (crc_next[14:0] != 15'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= PEC_SEED;
    end else if (ctl.accept) begin
      crc <= ctl.frame_end ? PEC_SEED : crc_next;
    end
  end

endmodule

### hdl/pec15rfc_frame.sv
// Frame sequencer: byte position, chip count, sticky error, cell code assembly.
// Depends on pec15rfc_pkg and pec15rfc_crc.
module pec15rfc_frame import pec15rfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [NUM_ICS_W-1:0] cfg_data,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic                 first_byte,
  input  logic [1:0]           register_group,
  output logic                 res_valid,
  output result_t              res
);

  logic [NUM_ICS_W-1:0] num_ics;
  logic [2:0]           byte_position;
  logic [7:0]           low_byte_hold;
  logic [CHIP_W-1:0]    chip_counter;
  logic                 sticky_error;
  logic [1:0]           group_latch;

  logic [2:0]           pos_eff;
  logic [CHIP_W-1:0]    chip_eff;
  logic                 sticky_eff;
  logic [1:0]           group_eff;
  logic [NUM_ICS_W-1:0] chips_in_use;
  logic                 last;
  logic                 pec_bad;
  logic [3:0]           group_base;
  crc_ctl_t             crc_ctl;

  logic [2:0]           byte_position_next;
  logic [CHIP_W-1:0]    chip_counter_next;
  logic                 sticky_error_next;
  logic                 hold_load;

  // A first-byte mark restarts the read before the byte is handled
  always_comb begin
    pos_eff    = first_byte ? 3'd0 : byte_position;
    chip_eff   = first_byte ? '0 : chip_counter;
    sticky_eff = first_byte ? 1'b0 : sticky_error;
    group_eff  = first_byte ? register_group : group_latch;
  end

  // Clamp the configured chain length
  always_comb begin
    chips_in_use = num_ics;
    if (num_ics == '0) begin
      chips_in_use = NUM_ICS_W'(1);
    end else if (num_ics > CHIP_LIMIT) begin
      chips_in_use = CHIP_LIMIT;
    end
  end

  assign last       = (NUM_ICS_W'(chip_eff) + NUM_ICS_W'(1)) >= chips_in_use;
  assign group_base = {1'b0, group_eff, 1'b0} + {2'b00, group_eff};

  assign crc_ctl.accept    = accept;
  assign crc_ctl.restart   = first_byte;
  assign crc_ctl.frame_end = (pos_eff == POS_CHECK_HI);

  pec15rfc_crc u_crc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (crc_ctl),
    .rx_byte (rx_byte),
    .pec_bad (pec_bad)
  );

  // Result and next state per byte position
  always_comb begin
    res_valid          = 1'b0;
    res                = '0;
    res.ic_index       = chip_eff;
    hold_load          = 1'b0;
    byte_position_next = pos_eff;
    chip_counter_next  = chip_eff;
    sticky_error_next  = sticky_eff;
    if (pos_eff < POS_CHECK_LO) begin
      byte_position_next = pos_eff + 3'd1;
      if (!pos_eff[0]) begin
        hold_load = 1'b1;
      end else begin
        res_valid       = 1'b1;
        res.kind        = KIND_CELL;
        res.cell_number = group_base + {2'b00, pos_eff[2:1]};
        res.cell_code   = {rx_byte, low_byte_hold};
      end
    end else if (pos_eff == POS_CHECK_LO) begin
      byte_position_next = POS_CHECK_HI;
    end else begin
      res_valid          = 1'b1;
      res.kind           = KIND_STATUS;
      res.frame_pec_bad  = pec_bad;
      res.read_pec_bad   = sticky_eff | pec_bad;
      res.last_frame     = last;
      sticky_error_next  = sticky_eff | pec_bad;
      byte_position_next = 3'd0;
      chip_counter_next  = last ? '0 : chip_eff + CHIP_W'(1);
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_ics <= NUM_ICS_RESET;
    end else if (cfg_we) begin
      num_ics <= cfg_data;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      low_byte_hold <= 8'd0;
      chip_counter  <= '0;
      sticky_error  <= 1'b0;
      group_latch   <= 2'd0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      chip_counter  <= chip_counter_next;
      sticky_error  <= sticky_error_next;
      group_latch   <= group_eff;
      if (hold_load) begin
        low_byte_hold <= rx_byte;
      end
    end
  end

endmodule

### hdl/pec15_read_frame_checker_top.sv
// Top level of the PEC-15 read frame checker: ports, output register.
// Depends on pec15rfc_pkg, pec15rfc_frame (which holds pec15rfc_crc).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one received chain byte per
//   transaction with first_byte and register_group. Bytes form 8-byte frames
//   per chip: six data bytes, two check bytes.
//   Output channel (out_valid/out_ready) carries at most one result per byte:
//   a cell code on every second data byte, a frame status on the last check
//   byte. Other bytes give no result.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes num_ics; always ready.
//   A result is registered and appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while in_ready is high; the CRC update is a byte-wide table
//   step folded into the same cycle as the sequencer.
//   A single output register sits between the sides; in_ready stays high
//   while it is empty or being drained in the same cycle, so a stalled
//   receiver holds the result and stops input only while the register is full.
//   Reset (rst, synchronous): num_ics returns to 1, the frame state clears,
//   the remainder takes its seed and the output register empties.
module pec15_read_frame_checker_top import pec15rfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        first_byte,
  input  logic [1:0]  register_group,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [3:0]  ic_index,
  output logic [3:0]  cell_number,
  output logic [15:0] cell_code,
  output logic        frame_pec_bad,
  output logic        read_pec_bad,
  output logic        last_frame
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  pec15rfc_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .rx_byte        (rx_byte),
    .first_byte     (first_byte),
    .register_group (register_group),
    .res_valid      (res_valid),
    .res            (res)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_res <= res;
    end
  end

  assign kind          = out_res.kind;
  assign ic_index      = out_res.ic_index;
  assign cell_number   = out_res.cell_number;
  assign cell_code     = out_res.cell_code;
  assign frame_pec_bad = out_res.frame_pec_bad;
  assign read_pec_bad  = out_res.read_pec_bad;
  assign last_frame    = out_res.last_frame;

endmodule
